// ===== rtl/core/bsa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared constants and types of the safety-checking resource allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int DEF_CUSTOMERS   = 8;
  localparam int DEF_RESOURCES   = 4;
  localparam int DEF_COUNT_WIDTH = 8;

  localparam int AMOUNT_FIELDS = 4;
  localparam int AMOUNT_WIDTH  = 8;
  localparam int REG_COUNT     = 4;

  typedef enum logic [1:0] {
    REQ_ACQUIRE = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_CLAIM   = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_GRANTED       = 3'd0,
    ST_OVER_NEED     = 3'd1,
    ST_OVER_FREE     = 3'd2,
    ST_UNSAFE        = 3'd3,
    ST_RELEASED      = 3'd4,
    ST_OVER_RELEASE  = 3'd5,
    ST_CLAIM_SET     = 3'd6,
    ST_CLAIM_REFUSED = 3'd7
  } status_t;

endpackage : bsa_pkg
`default_nettype wire

// ===== rtl/core/bankers_safety_allocator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bankers_safety_allocator_unit
// Deadlock-avoiding resource allocator with a safety check per acquire request.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel: drive in_req_type, in_customer, in_amount_0..3 and pulse
//    start while busy is low; the word is taken at that edge.
//  - Result channel: out_strobe is high for one cycle with out_status and
//    out_customer_echo; the receiver cannot stall it.
//  - Configuration: APB writes of total_units_r0..r3 at 0x0, 0x4, 0x8, 0xC.
//    Each write reloads free counts from the totals and clears the per
//    customer tables by a sweep, during which busy is high.
//  - Sequence: release, claim and refused words pass read, evaluate and done
//    states; the strobe is registered from the done state.
//    An acquire that passes the checks writes back on trial and runs the
//    safety scan: an issue state, then up to CUSTOMERS passes over the single
//    read port of the held/need memory, then the done state. An unsafe result
//    writes the rollback as the scan ends, before the done state.
//  - Throughput: busy drops in the strobe cycle; the next word can be taken
//    at the edge that ends it.
//  - Reset: totals and free counts go to zero and the tables are swept clear
//    (busy high) before the first word is taken.
// ----------------------------------------------------------------------------
module bankers_safety_allocator_unit import bsa_pkg::*; #(
  parameter int CUSTOMERS   = DEF_CUSTOMERS,
  parameter int RESOURCES   = DEF_RESOURCES,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [2:0]  in_customer,
  input  wire logic [7:0]  in_amount_0,
  input  wire logic [7:0]  in_amount_1,
  input  wire logic [7:0]  in_amount_2,
  input  wire logic [7:0]  in_amount_3,
  output logic             out_strobe,
  output logic [2:0]       out_status,
  output logic [2:0]       out_customer_echo,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CW = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1;
  localparam int RW = RESOURCES * COUNT_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  typedef logic [RESOURCES-1:0][COUNT_WIDTH-1:0] vec_t;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_WAIT  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t               state_r, state_nxt;
  vec_t                 total_r, total_nxt;
  vec_t                 free_r, free_nxt;
  logic [CW-1:0]        clr_r, clr_nxt;
  logic [1:0]           kind_r;
  logic [2:0]           cust_r;
  vec_t                 amt_r;
  logic [2:0]           stat_r, stat_nxt;
  logic                 strobe_r, strobe_nxt;

  // held/need memory, one word per customer
  logic [RW-1:0]        held_mem [CUSTOMERS];
  logic [RW-1:0]        need_mem [CUSTOMERS];
  logic                 we;
  logic [CW-1:0]        waddr;
  vec_t                 wheld, wneed;
  logic                 re;
  logic [CW-1:0]        raddr;
  vec_t                 rheld_r, rneed_r;

  // scan interface
  logic                 scan_start;
  logic                 scan_done;
  logic                 scan_safe;
  logic                 scan_re;
  logic [CW-1:0]        scan_addr;

  logic                 cfg_wr;
  logic [$clog2(REG_COUNT)-1:0] cfg_idx;
  logic                 valid_c;
  logic [CW-1:0]        cidx;
  logic                 over_need, over_free, over_held, claim_bad;
  vec_t                 in_amt;
  vec_t                 held_add, held_sub, need_add, need_sub;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    prdata = '0;
    if (int'(cfg_idx) < RESOURCES) prdata[COUNT_WIDTH-1:0] = total_r[cfg_idx];
  end

  // Gather amounts; resources past the fields read zero
  always_comb begin
    for (int r = 0; r < RESOURCES; r++) begin
      unique case (r)
        0: in_amt[r] = COUNT_WIDTH'(in_amount_0);
        1: in_amt[r] = COUNT_WIDTH'(in_amount_1);
        2: in_amt[r] = COUNT_WIDTH'(in_amount_2);
        3: in_amt[r] = COUNT_WIDTH'(in_amount_3);
        default: in_amt[r] = '0;
      endcase
    end
  end

  assign valid_c = (32'(cust_r) < CUSTOMERS);
  assign cidx    = CW'(cust_r);

  always_comb begin
    over_need = 1'b0; over_free = 1'b0; over_held = 1'b0; claim_bad = 1'b0;
    for (int r = 0; r < RESOURCES; r++) begin
      if (amt_r[r] > rneed_r[r]) over_need = 1'b1;
      if (amt_r[r] > free_r[r])  over_free = 1'b1;
      if (amt_r[r] > rheld_r[r]) over_held = 1'b1;
      if (rheld_r[r] != '0 || amt_r[r] > total_r[r]) claim_bad = 1'b1;
      held_add[r] = rheld_r[r] + amt_r[r];
      held_sub[r] = rheld_r[r] - amt_r[r];
      need_add[r] = rneed_r[r] + amt_r[r];
      need_sub[r] = rneed_r[r] - amt_r[r];
    end
  end

  // Control sequence
  always_comb begin
    state_nxt  = state_r;
    total_nxt  = total_r;
    free_nxt   = free_r;
    clr_nxt    = clr_r;
    stat_nxt   = stat_r;
    strobe_nxt = 1'b0;
    we         = 1'b0;
    waddr      = cidx;
    wheld      = rheld_r;
    wneed      = rneed_r;
    re         = 1'b0;
    raddr      = cidx;
    scan_start = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        wheld = '0;
        wneed = '0;
        clr_nxt = clr_r + CW'(1);
        if (clr_r == CW'(CUSTOMERS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_nxt = S_READ;
      end
      S_READ: begin
        re = valid_c;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_DONE;
        unique case (req_type_t'(kind_r))
          REQ_ACQUIRE: begin
            if (!valid_c || over_need) stat_nxt = ST_OVER_NEED;
            else if (over_free)        stat_nxt = ST_OVER_FREE;
            else begin
              we    = 1'b1;
              wheld = held_add;
              wneed = need_sub;
              for (int r = 0; r < RESOURCES; r++) free_nxt[r] = free_r[r] - amt_r[r];
              state_nxt = S_SCAN;
            end
          end
          REQ_RELEASE: begin
            if (!valid_c || over_held) stat_nxt = ST_OVER_RELEASE;
            else begin
              we    = 1'b1;
              wheld = held_sub;
              wneed = need_add;
              for (int r = 0; r < RESOURCES; r++) free_nxt[r] = free_r[r] + amt_r[r];
              stat_nxt = ST_RELEASED;
            end
          end
          REQ_CLAIM: begin
            if (!valid_c || claim_bad) stat_nxt = ST_CLAIM_REFUSED;
            else begin
              we    = 1'b1;
              wneed = amt_r;
              stat_nxt = ST_CLAIM_SET;
            end
          end
          default: stat_nxt = ST_CLAIM_REFUSED;
        endcase
      end
      S_SCAN: begin
        scan_start = 1'b1;
        state_nxt  = S_WAIT;
      end
      S_WAIT: begin
        re    = scan_re;
        raddr = scan_addr;
        if (scan_done) begin
          state_nxt = S_DONE;
          if (scan_safe) stat_nxt = ST_GRANTED;
          else begin
            stat_nxt = ST_UNSAFE;
            // roll back; rheld_r/rneed_r still hold the original entry
            we    = 1'b1;
            wheld = rheld_r;
            wneed = rneed_r;
            for (int r = 0; r < RESOURCES; r++) free_nxt[r] = free_r[r] + amt_r[r];
          end
        end
      end
      S_DONE: begin
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_wr && int'(cfg_idx) < RESOURCES) begin
      total_nxt[cfg_idx] = (pwdata[7:0] > 8'(CMAX)) ? CMAX : COUNT_WIDTH'(pwdata[7:0]);
      free_nxt  = total_nxt;
      clr_nxt   = '0;
      state_nxt = S_CLEAR;
    end
  end

  // Memory ports; the scan reads are held apart from the entry latch
  logic [RW-1:0] rd_h, rd_n;
  always_ff @(posedge clk) begin
    if (we) begin
      held_mem[waddr] <= wheld;
      need_mem[waddr] <= wneed;
    end
    if (re) begin
      rd_h <= held_mem[raddr];
      rd_n <= need_mem[raddr];
    end
    // latch the entry only on its own read, ready for evaluation
    if (state_r == S_READ) begin
      rheld_r <= held_mem[raddr];
      rneed_r <= need_mem[raddr];
    end
  end

  bsa_scan #(
    .CUSTOMERS   (CUSTOMERS),
    .RESOURCES   (RESOURCES),
    .COUNT_WIDTH (COUNT_WIDTH),
    .CW          (CW)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_start),
    .free_in (free_r),
    .rd_en   (scan_re),
    .rd_addr (scan_addr),
    .rd_need (rd_n),
    .rd_held (rd_h),
    .done    (scan_done),
    .safe    (scan_safe)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      total_r  <= '0;
      free_r   <= '0;
      clr_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      total_r  <= total_nxt;
      free_r   <= free_nxt;
      clr_r    <= clr_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Capture the word when taken
  always_ff @(posedge clk) begin
    stat_r <= stat_nxt;
    if (start && !busy) begin
      kind_r <= in_req_type;
      cust_r <= in_customer;
      amt_r  <= in_amt;
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_strobe        = strobe_r;
  assign out_status        = stat_r;
  assign out_customer_echo = cust_r;

  // a result word follows the done state
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == S_DONE)) else $error("stray result");
  // no word taken while busy
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> $past(state_r == S_IDLE)) else $error("bad take");
  // a scan starts only from a checked request
  a_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_start |-> kind_r == REQ_ACQUIRE) else $error("scan w/o request");

endmodule : bankers_safety_allocator_unit
`default_nettype wire

// ===== rtl/core/bsa_scan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsa_scan
// Safety scan: walks customers through the need/held memory port, one entry
// per cycle, adding held units of each unfinished customer whose need fits the work
// vector, until a pass makes no progress or all customers are done.
// ----------------------------------------------------------------------------
module bsa_scan import bsa_pkg::*; #(
  parameter int CUSTOMERS   = DEF_CUSTOMERS,
  parameter int RESOURCES   = DEF_RESOURCES,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
  parameter int CW          = $clog2(CUSTOMERS)
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  input  wire logic [RESOURCES-1:0][COUNT_WIDTH-1:0] free_in,
  // memory read port, data returns in the cycle after the address
  output logic                                       rd_en,
  output logic [CW-1:0]                              rd_addr,
  input  wire logic [RESOURCES-1:0][COUNT_WIDTH-1:0] rd_need,
  input  wire logic [RESOURCES-1:0][COUNT_WIDTH-1:0] rd_held,
  output logic                                       done,
  output logic                                       safe
);

  localparam int NW = $clog2(CUSTOMERS + 1);
  // work may grow past the count range only by held sums; keep headroom
  localparam int WW = COUNT_WIDTH + CW + 1;

  logic                                 busy_r, busy_nxt;
  logic                                 chk_r, chk_nxt;     // data of chk_c_r valid
  logic [CW-1:0]                        addr_r, addr_nxt;
  logic [CW-1:0]                        chk_c_r, chk_c_nxt;
  logic [RESOURCES-1:0][WW-1:0]         work_r, work_nxt;
  logic [CUSTOMERS-1:0]                 fin_r, fin_nxt;
  logic [NW-1:0]                        nfin_r, nfin_nxt;
  logic                                 prog_r, prog_nxt;
  logic                                 done_r, done_nxt;
  logic                                 safe_r, safe_nxt;
  logic                                 fits;
  logic                                 last_c;
  logic                                 take;
  logic [NW-1:0]                        nfin_new;
  logic                                 prog_new;

  always_comb begin
    fits = 1'b1;
    for (int r = 0; r < RESOURCES; r++) begin
      if (WW'(rd_need[r]) > work_r[r]) fits = 1'b0;
    end
  end

  assign take     = chk_r && !fin_r[chk_c_r] && fits;
  assign last_c   = (chk_c_r == CW'(CUSTOMERS - 1));
  assign nfin_new = take ? nfin_r + NW'(1) : nfin_r;
  assign prog_new = prog_r | take;

  // Sequence the scan: issue address, then check returned entry
  always_comb begin
    busy_nxt   = busy_r;
    chk_nxt    = 1'b0;
    addr_nxt   = addr_r;
    chk_c_nxt  = chk_c_r;
    work_nxt   = work_r;
    fin_nxt    = fin_r;
    nfin_nxt   = nfin_r;
    prog_nxt   = prog_r;
    done_nxt   = 1'b0;
    safe_nxt   = safe_r;
    rd_en      = 1'b0;
    rd_addr    = addr_r;
    if (start) begin
      busy_nxt = 1'b1;
      addr_nxt = '0;
      fin_nxt  = '0;
      nfin_nxt = '0;
      prog_nxt = 1'b0;
      for (int r = 0; r < RESOURCES; r++) work_nxt[r] = WW'(free_in[r]);
    end else if (busy_r) begin
      if (chk_r) begin
        if (take) begin
          fin_nxt[chk_c_r] = 1'b1;
          for (int r = 0; r < RESOURCES; r++) work_nxt[r] = work_r[r] + WW'(rd_held[r]);
        end
        nfin_nxt = nfin_new;
        prog_nxt = prog_new;
      end
      if (chk_r && last_c) begin
        // end of a pass: stop on completion or stall
        if (nfin_new == NW'(CUSTOMERS) || !prog_new) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
          safe_nxt = (nfin_new == NW'(CUSTOMERS));
        end else begin
          prog_nxt  = 1'b0;
          rd_en     = 1'b1;
          rd_addr   = '0;
          chk_nxt   = 1'b1;
          chk_c_nxt = '0;
          addr_nxt  = CW'(1);
        end
      end else if (!chk_r || !last_c) begin
        if (!chk_r && addr_r != '0) begin
          // wait: next check arrives this cycle
          chk_nxt = 1'b0;
        end
        if (addr_r != '0 || !chk_r) begin
          if (!(chk_r && chk_c_r == CW'(CUSTOMERS - 1))) begin
            rd_en     = (addr_r <= CW'(CUSTOMERS - 1)) && !(chk_r == 1'b0 && addr_r != '0);
            rd_addr   = addr_r;
            chk_nxt   = rd_en;
            chk_c_nxt = addr_r;
            if (rd_en) addr_nxt = (addr_r == CW'(CUSTOMERS - 1)) ? '0 : addr_r + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      chk_r  <= 1'b0;
      done_r <= 1'b0;
      safe_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      chk_r  <= chk_nxt;
      done_r <= done_nxt;
      safe_r <= safe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    chk_c_r <= chk_c_nxt;
    work_r  <= work_nxt;
    fin_r   <= fin_nxt;
    nfin_r  <= nfin_nxt;
    prog_r  <= prog_nxt;
  end

  assign done = done_r;
  assign safe = safe_r;

  // a scan never reports done while still reading
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("scan done while busy");
  // finish count never exceeds customers
  a_nfin: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> nfin_r <= NW'(CUSTOMERS)) else $error("finish count overflow");
  // each check follows a read
  a_chk: assert property (@(posedge clk) disable iff (!rst_n)
    chk_r |-> $past(rd_en)) else $error("check without read");

endmodule : bsa_scan
`default_nettype wire
